// ----- hdl/bbe_pkg.sv -----
`timescale 1ns / 1ps

package bbe_pkg;

   // Frame geometry.
   localparam int IMAGE_WIDTH  = 512;
   localparam int IMAGE_HEIGHT = 512;
   localparam int COL_W        = $clog2(IMAGE_WIDTH);
   localparam int ROW_W        = $clog2(IMAGE_HEIGHT);

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);

   // Register reset value and result codes.
   localparam logic [7:0] THRESHOLD_RESET = 8'd10;
   localparam logic [7:0] PIXEL_ON        = 8'd255;
   localparam logic [7:0] PIXEL_OFF       = 8'd0;

   // Item function codes.
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [7:0] boundary_pixel;
      logic       frame_last;
   } rsp_type;

endpackage

// ----- hdl/binary_boundary_extract.sv -----
`timescale 1ns / 1ps

// Boundary extraction of a thresholded grey image with a 3x3 square erosion.
// Pixels arrive on the req_ channel in raster order, one per transfer, with
// func set to pixel. A pixel at or below the csr_ threshold (reset value 10)
// is foreground. Each result on the rsp_ channel is 255 where a foreground
// pixel has a background neighbour inside the frame, else 0.
// The result for a pixel is completed by the transfer of the pixel one row
// and one column further on; the last row plus one results of a frame need
// one flush transfer each, and the final result carries frame_last. Flush
// transfers before the last pixel of a frame are taken and dropped.
// A result passes the memory stage and the output register before rsp_valid.
// Throughput: one item per cycle unless rsp_ stalls, set by the single line
// memory, read at one column and written back at the previous one each cycle.
// Reset clears the frame counters and restores the threshold; the line
// memory is not cleared, as every entry is written before a result uses it.
// When the receiver stalls, the result waits in the output register and one
// more item can still be taken into the memory stage; req_ready then falls.

module binary_boundary_extract (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bbe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bbe_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

   import bbe_pkg::*;

   // Control and payload carried with an item into the memory stage.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             wr;
      logic             new_bit;
      logic             emit;
      logic             top_ok;
      logic             bot_ok;
      logic             left_ok;
      logic             right_ok;
      logic             last;
   } stage_type;

   // A window column: bit 0 upper row, bit 1 middle row, bit 2 lower row.
   typedef logic [2:0] column_type;

   logic [7:0]       threshold_ff;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic             in_done_ff, in_done_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic             s1_valid_ff, s1_valid_in;
   stage_type        s1_ff, s1_in;
   column_type       col0_ff, col1_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic             req_fire, s1_fire, out_free;
   logic             is_pix, col_item, pix_emit, emit0, last_out;
   logic             ram_wr_en, ram_rd_en;
   logic [1:0]       ram_wr_data, ram_rd_data;
   column_type       fresh, win_left, win_centre, win_right;
   logic             eroded, boundary;

   function automatic column_type mask_rows(column_type c, logic top_ok, logic bot_ok);
      column_type m;
      m[0] = top_ok ? c[0] : 1'b1;
      m[1] = c[1];
      m[2] = bot_ok ? c[2] : 1'b1;
      return m;
   endfunction

   // Configuration register, always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         threshold_ff <= csr_data;
      end
   end

   // Handshake: the memory stage moves on when its result has a place to go.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_ff.emit || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // Item decode. Once all pixels are in, every item drains one result.
   always_comb begin
      is_pix = 1'b0;
      case (req_data.func)
         FUNC_PIXEL: is_pix = !in_done_ff;
         FUNC_FLUSH: is_pix = 1'b0;
         default:    is_pix = 1'b0;
      endcase
   end

   assign col_item = in_done_ff || is_pix;
   assign pix_emit = is_pix && (in_row_ff != '0) &&
                     !((in_row_ff == ROW_W'(1)) && (in_col_ff == '0));
   assign emit0    = in_done_ff || pix_emit;
   assign last_out = (out_row_ff == ROW_LAST) && (out_col_ff == COL_LAST);

   // Frame position counters for incoming columns and outgoing results.
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      in_done_in = in_done_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (req_fire && col_item) begin
         in_col_in = (in_col_ff == COL_LAST) ? '0 : in_col_ff + COL_W'(1);
      end
      if (req_fire && is_pix && (in_col_ff == COL_LAST)) begin
         in_row_in = (in_row_ff == ROW_LAST) ? '0 : in_row_ff + ROW_W'(1);
         if (in_row_ff == ROW_LAST) begin
            in_done_in = 1'b1;
         end
      end
      if (req_fire && emit0) begin
         out_col_in = (out_col_ff == COL_LAST) ? '0 : out_col_ff + COL_W'(1);
         if (out_col_ff == COL_LAST) begin
            out_row_in = out_row_ff + ROW_W'(1);
         end
         if (last_out) begin
            in_col_in  = '0;
            in_row_in  = '0;
            in_done_in = 1'b0;
            out_col_in = '0;
            out_row_in = '0;
         end
      end
   end

   // Load of the memory stage.
   always_comb begin
      s1_in          = s1_ff;
      s1_valid_in    = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in    = col_item;
         s1_in.col      = in_col_ff;
         s1_in.wr       = is_pix;
         s1_in.new_bit  = (req_data.pixel_value <= threshold_ff);
         s1_in.emit     = emit0;
         s1_in.top_ok   = (out_row_ff != '0);
         s1_in.bot_ok   = (out_row_ff != ROW_LAST);
         s1_in.left_ok  = (out_col_ff != '0);
         s1_in.right_ok = (out_col_ff != COL_LAST);
         s1_in.last     = last_out;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Line memory: each column holds the two rows above the incoming row,
   // bit 1 the older row and bit 0 the newer. The write lands one column
   // behind the read, so the two ports never meet at one address.
   assign ram_rd_en   = req_fire && col_item;
   assign ram_wr_en   = s1_fire && s1_ff.wr;
   assign ram_wr_data = {ram_rd_data[0], s1_ff.new_bit};

   bbe_ram #(
      .WIDTH (2),
      .DEPTH (IMAGE_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_ff.col),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (in_col_ff),
      .rd_data (ram_rd_data)
   );

   // Window evaluation. Neighbours outside the frame count as set.
   assign fresh      = {s1_ff.wr ? s1_ff.new_bit : 1'b1, ram_rd_data[0], ram_rd_data[1]};
   assign win_left   = s1_ff.left_ok ? mask_rows(col0_ff, s1_ff.top_ok, s1_ff.bot_ok)
                                     : 3'b111;
   assign win_centre = mask_rows(col1_ff, s1_ff.top_ok, s1_ff.bot_ok);
   assign win_right  = s1_ff.right_ok ? mask_rows(fresh, s1_ff.top_ok, s1_ff.bot_ok)
                                      : 3'b111;
   assign eroded     = &{win_left, win_centre, win_right};
   assign boundary   = col1_ff[1] && !eroded;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_done_ff   <= 1'b0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_done_ff  <= in_done_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_fire && s1_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: stage contents, window columns and result.
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (s1_fire) begin
         col0_ff <= col1_ff;
         col1_ff <= fresh;
      end
      if (s1_fire && s1_ff.emit) begin
         rsp_data_ff.boundary_pixel <= boundary ? PIXEL_ON : PIXEL_OFF;
         rsp_data_ff.frame_last     <= s1_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The two memory ports never address the same column in one cycle.
   a_ram_ports_apart : assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && ram_rd_en |-> s1_ff.col != in_col_ff)
      else $error("line memory read and write collide");

   // A held memory stage keeps its contents.
   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_ff))
      else $error("memory stage lost a held item");

   // The frame's final result restarts both counters.
   a_frame_restart : assert property (@(posedge clock) disable iff (reset)
      req_fire && emit0 && last_out |=>
         in_col_ff == '0 && in_row_ff == '0 && !in_done_ff &&
         out_col_ff == '0 && out_row_ff == '0)
      else $error("frame counters not restarted");

   // While draining, results are in the last two rows.
   a_drain_rows : assert property (@(posedge clock) disable iff (reset)
      in_done_ff |-> out_row_ff >= ROW_W'(IMAGE_HEIGHT - 2))
      else $error("drain started with results outstanding above the last rows");

endmodule

// ----- hdl/bbe_ram.sv -----
`timescale 1ns / 1ps

module bbe_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
